### rtl/drft_pkg.sv
package drft_pkg;

  localparam int BLK_W  = 6;
  localparam int OFF_W  = 32;
  localparam int LEN_W  = 32;
  localparam int FLEN_W = 33;
  localparam int RS_W   = 27;
  localparam int SUM_W  = 33;
  localparam int CFG_IDX_W = 1;

  localparam logic [RS_W-1:0] RS_RESET = RS_W'(1024);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COHERENT   = 1'd1;

  // item modes
  localparam logic MODE_MARK  = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  typedef struct packed {
    logic wr;
    logic clr;
  } st_req_t;

  typedef struct packed {
    logic              vld;
    logic [OFF_W-1:0]  offset;
    logic [FLEN_W-1:0] length;
    logic              last;
  } scan_emit_t;

endpackage

### rtl/drft_if.sv
interface drft_in_if;
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic [drft_pkg::BLK_W-1:0] block_index;
  logic [drft_pkg::OFF_W-1:0] byte_offset;
  logic [drft_pkg::LEN_W-1:0] byte_length;

  modport source (output valid, mode, block_index, byte_offset, byte_length, input ready);
  modport sink   (input valid, mode, block_index, byte_offset, byte_length, output ready);
endinterface

interface drft_out_if;
  logic                        valid;
  logic                        ready;
  logic [drft_pkg::OFF_W-1:0]  flush_offset;
  logic [drft_pkg::FLEN_W-1:0] flush_length;
  logic                        whole_block;
  logic                        nothing_dirty;
  logic                        last_run;

  modport source (output valid, flush_offset, flush_length, whole_block, nothing_dirty,
                  last_run, input ready);
  modport sink   (input valid, flush_offset, flush_length, whole_block, nothing_dirty,
                  last_run, output ready);
endinterface

### rtl/dirty_range_flush_tracker.sv
// Dirty range tracker: one RANGES-bit dirty mask per staging block, each bit covering
// range_size bytes. A mark item (mode 0) sets the bits touched by a byte range; a mark
// that is empty, under coherent mode or for a block beyond NUM_BLOCKS is dropped, and one
// that runs past the block end sets the whole mask. Otherwise the single compare-subtract
// divider works out the first and the final mask bit one quotient bit per cycle. A flush
// item (mode 1) reads the mask and gives one result for an empty block, a full mask or a
// range size or RANGES that is not a power of two (whole block), or scans the mask one
// bit per cycle, giving one result per run of set bits; both stall while the output
// register is held. The block is not ready during an item.
// Masks read as empty after reset through per-block valid bits; there is no clearing pass.
module dirty_range_flush_tracker #(
  parameter int NUM_BLOCKS = 64,
  parameter int RANGES     = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [drft_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [drft_pkg::RS_W-1:0]       cfg_wdata,
  drft_in_if.sink                         in_if,
  drft_out_if.source                      out_if
);

  localparam int  QW          = $clog2(RANGES);
  localparam int  AW          = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam bit  RANGES_POW2 = (RANGES & (RANGES - 1)) == 0;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_MCHK  = 8'b0000_0010,
    ST_MDIV0 = 8'b0000_0100,
    ST_MDIV1 = 8'b0000_1000,
    ST_MWR   = 8'b0001_0000,
    ST_FLD   = 8'b0010_0000,
    ST_FDEC  = 8'b0100_0000,
    ST_FSCAN = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [drft_pkg::RS_W-1:0]  range_size_r;
  logic                       coherent_r;

  logic [drft_pkg::BLK_W-1:0] blk_r;
  logic                       blk_ok_r;
  logic [drft_pkg::OFF_W-1:0] off_r;
  logic [drft_pkg::LEN_W-1:0] len_r;
  logic [drft_pkg::SUM_W-1:0] end_r;
  logic [QW-1:0]              first_r;
  logic                       full_r, full_nxt;

  logic [drft_pkg::SUM_W-1:0] block_size;
  logic [drft_pkg::SUM_W-1:0] sum;
  logic                       rs_pow2, blk_pow2;
  logic                       in_blk_ok;
  logic                       accept;

  logic                       div_start;
  logic [drft_pkg::SUM_W-1:0] div_dividend;
  logic                       div_done;
  logic [QW-1:0]              div_quot;

  drft_pkg::st_req_t          st_req;
  logic [RANGES-1:0]          st_wdata, st_rdata, mask_v, range_bits;
  logic                       st_rvld;

  logic                       scan_load, scan_busy;
  drft_pkg::scan_emit_t       scan_emit;

  logic                        out_vld_r;
  logic [drft_pkg::OFF_W-1:0]  out_off_r, out_off_nxt;
  logic [drft_pkg::FLEN_W-1:0] out_len_r, out_len_nxt;
  logic                        out_whole_r, out_whole_nxt;
  logic                        out_empty_r, out_empty_nxt;
  logic                        out_last_r, out_last_nxt;
  logic                        out_load, slot_free;
  logic                        fdec_empty, fdec_single;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_size_r <= drft_pkg::RS_RESET;
      coherent_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        drft_pkg::REG_RANGE_SIZE: range_size_r <= cfg_wdata;
        drft_pkg::REG_COHERENT:   coherent_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign block_size = drft_pkg::SUM_W'(range_size_r) * drft_pkg::SUM_W'(RANGES);
  assign rs_pow2    = (range_size_r != '0) &&
                      ((range_size_r & (range_size_r - 1'b1)) == '0);
  assign blk_pow2   = RANGES_POW2 && rs_pow2;
  assign sum        = {1'b0, off_r} + {1'b0, len_r};
  assign in_blk_ok  = {1'b0, in_if.block_index} < (drft_pkg::BLK_W + 1)'(NUM_BLOCKS);

  assign in_if.ready = state_r == ST_IDLE;
  assign accept      = in_if.valid && in_if.ready;

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    full_nxt     = full_r;
    div_start    = 1'b0;
    div_dividend = {1'b0, off_r};
    st_req       = '0;
    scan_load    = 1'b0;
    out_load     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_if.mode == drft_pkg::MODE_FLUSH) begin
            state_nxt = ST_FLD;
          end else if (in_if.byte_length != '0 && !coherent_r && in_blk_ok) begin
            state_nxt = ST_MCHK;
          end
        end
      end
      ST_MCHK: begin
        if (sum > block_size) begin
          full_nxt  = 1'b1;
          state_nxt = ST_MWR;
        end else begin
          full_nxt  = 1'b0;
          div_start = 1'b1;
          state_nxt = ST_MDIV0;
        end
      end
      ST_MDIV0: begin
        if (div_done) begin
          div_start    = 1'b1;
          div_dividend = end_r;
          state_nxt    = ST_MDIV1;
        end
      end
      ST_MDIV1: begin
        if (div_done) begin
          state_nxt = ST_MWR;
        end
      end
      ST_MWR: begin
        st_req.wr = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_FLD: begin
        state_nxt = ST_FDEC;
      end
      ST_FDEC: begin
        if (fdec_single) begin
          if (slot_free) begin
            out_load   = 1'b1;
            st_req.clr = blk_ok_r;
            state_nxt  = ST_IDLE;
          end
        end else begin
          scan_load  = 1'b1;
          st_req.clr = 1'b1;
          state_nxt  = ST_FSCAN;
        end
      end
      ST_FSCAN: begin
        out_load = scan_emit.vld && slot_free;
        if (!scan_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    full_r <= full_nxt;
    if (accept) begin
      blk_r    <= in_if.block_index;
      blk_ok_r <= in_blk_ok;
      off_r    <= in_if.byte_offset;
      len_r    <= in_if.byte_length;
    end
    if (state_r == ST_MCHK) begin
      end_r <= sum - 1'b1;
    end
    if (state_r == ST_MDIV0 && div_done) begin
      first_r <= div_quot;
    end
  end

  drft_div #(.QW(QW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (range_size_r),
    .done     (div_done),
    .quot     (div_quot)
  );

  // bits first..final; the final quotient stays in the divider
  always_comb begin
    for (int j = 0; j < RANGES; j++) begin
      range_bits[j] = (j >= int'(first_r)) && (j <= int'(div_quot));
    end
  end

  assign mask_v   = st_rvld ? st_rdata : '0;
  assign st_wdata = mask_v | (full_r ? {RANGES{1'b1}} : range_bits);

  drft_store #(.DEPTH(NUM_BLOCKS), .MW(RANGES), .AW(AW)) u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .addr  (blk_r[AW-1:0]),
    .req   (st_req),
    .wdata (st_wdata),
    .rdata (st_rdata),
    .rvld  (st_rvld)
  );

  assign fdec_empty  = !blk_ok_r || mask_v == '0;
  assign fdec_single = fdec_empty || (&mask_v) || !blk_pow2;

  drft_scan #(.MW(RANGES)) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (scan_load),
    .mask       (mask_v),
    .range_size (range_size_r),
    .slot_free  (slot_free),
    .busy       (scan_busy),
    .emit       (scan_emit)
  );

  // output register
  assign slot_free = !out_vld_r || out_if.ready;

  always_comb begin
    if (state_r == ST_FSCAN) begin
      out_off_nxt   = scan_emit.offset;
      out_len_nxt   = scan_emit.length;
      out_whole_nxt = 1'b0;
      out_empty_nxt = 1'b0;
      out_last_nxt  = scan_emit.last;
    end else begin
      out_off_nxt   = '0;
      out_len_nxt   = fdec_empty ? '0 : block_size;
      out_whole_nxt = !fdec_empty;
      out_empty_nxt = fdec_empty;
      out_last_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_if.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_off_r   <= out_off_nxt;
      out_len_r   <= out_len_nxt;
      out_whole_r <= out_whole_nxt;
      out_empty_r <= out_empty_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  assign out_if.valid         = out_vld_r;
  assign out_if.flush_offset  = out_off_r;
  assign out_if.flush_length  = out_len_r;
  assign out_if.whole_block   = out_whole_r;
  assign out_if.nothing_dirty = out_empty_r;
  assign out_if.last_run      = out_last_r;

endmodule

### rtl/drft_div.sv
module drft_div #(
  parameter int QW = 6
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [drft_pkg::SUM_W-1:0]  dividend,
  input  logic [drft_pkg::RS_W-1:0]   divisor,
  output logic                        done,
  output logic [QW-1:0]               quot
);

  localparam int KW = (QW > 1) ? $clog2(QW) : 1;

  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [KW-1:0]              k_r, k_nxt;
  logic [drft_pkg::SUM_W-1:0] rem_r, rem_nxt;
  logic [QW-1:0]              q_r, q_nxt;
  logic [drft_pkg::SUM_W-1:0] dvs;

  // one restoring compare-subtract per cycle, quotient bit k
  always_comb begin
    dvs      = drft_pkg::SUM_W'(divisor) << k_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    k_nxt    = k_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    if (start) begin
      rem_nxt  = dividend;
      q_nxt    = '0;
      k_nxt    = KW'(QW - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_r >= dvs) begin
        rem_nxt    = rem_r - dvs;
        q_nxt[k_r] = 1'b1;
      end
      if (k_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        k_nxt = k_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r   <= k_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

### rtl/drft_store.sv
module drft_store #(
  parameter int DEPTH = 64,
  parameter int MW    = 64,
  parameter int AW    = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [AW-1:0]     addr,
  input  drft_pkg::st_req_t req,
  input  logic [MW-1:0]     wdata,
  output logic [MW-1:0]     rdata,
  output logic              rvld
);

  logic [MW-1:0]    mem [DEPTH];
  logic [MW-1:0]    rdata_r;
  logic [DEPTH-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  // an entry never written since reset or since its last flush reads as empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.wr) begin
      vld_r[addr] <= 1'b1;
    end else if (req.clr) begin
      vld_r[addr] <= 1'b0;
    end
  end

  assign rdata = rdata_r;
  assign rvld  = vld_r[addr];

endmodule

### rtl/drft_scan.sv
module drft_scan #(
  parameter int MW = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  logic [MW-1:0]               mask,
  input  logic [drft_pkg::RS_W-1:0]   range_size,
  input  logic                        slot_free,
  output logic                        busy,
  output drft_pkg::scan_emit_t        emit
);

  logic [MW-1:0]              mask_r;
  logic                       in_run_r;
  logic [drft_pkg::SUM_W-1:0] pos_r;
  logic [drft_pkg::SUM_W-1:0] start_r;
  logic [drft_pkg::SUM_W-1:0] len_r;
  logic [drft_pkg::SUM_W-1:0] len_cur;
  logic [drft_pkg::SUM_W-1:0] off_cur;
  logic                       cur, nxt_set, adv;

  assign cur     = mask_r[0];
  assign nxt_set = mask_r[1];
  assign len_cur = (in_run_r ? len_r : '0) + drft_pkg::SUM_W'(range_size);
  assign off_cur = in_run_r ? start_r : pos_r;

  // a run closes on a set bit whose upper neighbour is clear
  always_comb begin
    emit.vld    = cur && !nxt_set;
    emit.offset = off_cur[drft_pkg::OFF_W-1:0];
    emit.length = len_cur;
    emit.last   = (mask_r >> 1) == '0;
  end

  assign adv  = !emit.vld || slot_free;
  assign busy = mask_r != '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r   <= '0;
      in_run_r <= 1'b0;
    end else if (load) begin
      mask_r   <= mask;
      in_run_r <= 1'b0;
    end else if (adv && busy) begin
      mask_r   <= mask_r >> 1;
      in_run_r <= cur && nxt_set;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pos_r <= '0;
    end else if (adv && busy) begin
      pos_r <= pos_r + drft_pkg::SUM_W'(range_size);
      if (cur) begin
        start_r <= off_cur;
        len_r   <= len_cur;
      end
    end
  end

endmodule

### test/dirty_range_flush_tracker_test.sv
module dirty_range_flush_tracker_test;
  import drft_pkg::*;

  typedef struct packed {
    logic [OFF_W-1:0]  offset;
    logic [FLEN_W-1:0] length;
    logic              whole;
    logic              empty;
    logic              last;
  } flush_req_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [RS_W-1:0]      cfg_wdata;

  drft_in_if  in_ch ();
  drft_out_if out_ch ();

  dirty_range_flush_tracker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_if     (in_ch),
    .out_if    (out_ch)
  );

  // shadow copy of the tracker state
  logic [63:0]     shadow_masks [64];
  logic [RS_W-1:0] shadow_range;
  logic            shadow_coherent;
  flush_req_t      pending_flushes [$];

  int mismatch_count = 0;
  int hold_req = 0;
  bit no_idle = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("dirty_range_flush_tracker_test failed");
    $finish;
  end

  function automatic void apply_mark(input logic [BLK_W-1:0] blk, input logic [OFF_W-1:0] off,
                                     input logic [LEN_W-1:0] len);
    logic [SUM_W-1:0] bsize;
    logic [SUM_W-1:0] span_end;
    logic [SUM_W-1:0] first_bit;
    logic [SUM_W-1:0] final_bit;
    if (len == 0 || shadow_coherent)
      return;
    bsize = SUM_W'(shadow_range) << 6;
    span_end = SUM_W'(off) + SUM_W'(len);
    // running past the block end (and any mark at zero range size) dirties everything
    if (span_end > bsize) begin
      shadow_masks[blk] = '1;
      return;
    end
    first_bit = SUM_W'(off) / SUM_W'(shadow_range);
    final_bit = (span_end - 1) / SUM_W'(shadow_range);
    for (int b = 0; b < 64; b++)
      if (b >= first_bit && b <= final_bit)
        shadow_masks[blk][b] = 1'b1;
  endfunction

  function automatic void apply_flush(input logic [BLK_W-1:0] blk);
    logic [63:0]  mask;
    logic [SUM_W-1:0] bsize;
    flush_req_t   run;
    flush_req_t   held;
    bit           have_held;
    int           b;
    int           start;
    mask = shadow_masks[blk];
    shadow_masks[blk] = '0;
    bsize = SUM_W'(shadow_range) << 6;
    run = '0;
    if (mask == 0) begin
      run.empty = 1'b1;
      run.last = 1'b1;
      pending_flushes = {pending_flushes, run};
    end else if (mask == '1 || shadow_range == 0 ||
                 (shadow_range & (shadow_range - 1)) != 0) begin
      run.length = bsize;
      run.whole = 1'b1;
      run.last = 1'b1;
      pending_flushes = {pending_flushes, run};
    end else begin
      have_held = 1'b0;
      held = '0;
      b = 0;
      while (b < 64) begin
        if (!mask[b]) begin
          b++;
        end else begin
          start = b;
          while (b < 64 && mask[b])
            b++;
          if (have_held)
            pending_flushes = {pending_flushes, held};
          held = '0;
          held.offset = OFF_W'(longint'(start) * longint'(shadow_range));
          held.length = FLEN_W'(longint'(b - start) * longint'(shadow_range));
          have_held = 1'b1;
        end
      end
      held.last = 1'b1;
      pending_flushes = {pending_flushes, held};
    end
  endfunction

  task automatic send_item(input logic mode, input logic [BLK_W-1:0] blk,
                           input logic [OFF_W-1:0] off, input logic [LEN_W-1:0] len);
    while (!no_idle && $urandom_range(99) < 9) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= mode;
    in_ch.block_index <= blk;
    in_ch.byte_offset <= off;
    in_ch.byte_length <= len;
    @(posedge clk);
    while (!in_ch.ready)
      @(posedge clk);
    if (mode == MODE_MARK)
      apply_mark(blk, off, len);
    else
      apply_flush(blk);
  endtask

  // wait for every flush result, then give a trailing mark time to finish
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_flushes.size() != 0)
      @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic set_config(input logic [RS_W-1:0] range_bytes, input logic coherent);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_RANGE_SIZE;
    cfg_wdata <= range_bytes;
    @(posedge clk);
    cfg_idx   <= REG_COHERENT;
    cfg_wdata <= RS_W'(coherent);
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_range = range_bytes;
    shadow_coherent = coherent;
  endtask

  task automatic send_random(input int count);
    longint bsize;
    longint span;
    longint off;
    longint len;
    logic [BLK_W-1:0] blk;
    int pick;
    for (int k = 0; k < count; k++) begin
      bsize = longint'(shadow_range) * 64;
      span = longint'(shadow_range) * $urandom_range(1, 5);
      if (span == 0)
        span = 1;
      // a small pool of blocks lets marks pile up into several runs
      blk = ($urandom_range(9) == 0) ? BLK_W'($urandom) : BLK_W'($urandom_range(3));
      pick = $urandom_range(99);
      if (pick < 30) begin
        send_item(MODE_FLUSH, blk, $urandom, $urandom);
      end else begin
        if (bsize != 0)
          off = longint'($urandom) % bsize;
        else
          off = longint'($urandom);
        len = 1 + longint'($urandom) % span;
        if (pick < 36) begin
          len = 0;
        end else if (pick < 42) begin
          off = longint'($urandom);
          len = longint'($urandom);
        end else if (pick < 48) begin
          off = bsize - len;
        end
        send_item(MODE_MARK, blk, OFF_W'(off), LEN_W'(len));
      end
    end
  endtask

  task automatic test_empty_after_reset();
    send_item(MODE_FLUSH, 6'd0, '0, '0);
    send_item(MODE_FLUSH, 6'd63, '1, '1);
  endtask

  task automatic test_mark_edges();
    send_item(MODE_MARK, 6'd0, 32'd0, 32'd0);
    send_item(MODE_MARK, 6'd0, 32'd0, 32'd1);
    send_item(MODE_MARK, 6'd0, 32'd5120, 32'd1024);
    send_item(MODE_MARK, 6'd0, 32'd65535, 32'd1);
    send_item(MODE_FLUSH, 6'd0, '0, '0);
    // ending exactly on the block end stays a plain range
    send_item(MODE_MARK, 6'd1, 32'd0, 32'd65536);
    send_item(MODE_FLUSH, 6'd1, '0, '0);
    send_item(MODE_MARK, 6'd2, '1, '1);
    send_item(MODE_MARK, 6'd63, 32'd65535, 32'd2);
    send_item(MODE_FLUSH, 6'd2, '0, '0);
    send_item(MODE_FLUSH, 6'd63, '0, '0);
    send_item(MODE_MARK, 6'd3, 32'd1023, 32'd2);
    send_item(MODE_FLUSH, 6'd3, '0, '0);
  endtask

  task automatic test_coherent_marks();
    send_item(MODE_MARK, 6'd4, 32'd0, 32'd100);
    settle();
    set_config(RS_RESET, 1'b1);
    send_item(MODE_MARK, 6'd4, 32'd8192, 32'd1);
    send_item(MODE_FLUSH, 6'd4, '0, '0);
  endtask

  task automatic test_range_sizes();
    settle();
    set_config(RS_W'(1000), 1'b0);
    send_item(MODE_MARK, 6'd5, 32'd0, 32'd1);
    send_item(MODE_FLUSH, 6'd5, '0, '0);
    settle();
    set_config('0, 1'b0);
    send_item(MODE_MARK, 6'd6, 32'd0, 32'd1);
    send_item(MODE_FLUSH, 6'd6, '0, '0);
    settle();
    set_config(RS_W'(67108864), 1'b0);
    send_item(MODE_MARK, 6'd7, 32'd4227858432, 32'd1);
    send_item(MODE_MARK, 6'd7, 32'd67108864, 32'd67108864);
    send_item(MODE_FLUSH, 6'd7, '0, '0);
  endtask

  task automatic test_random_traffic();
    settle();
    set_config(RS_RESET, 1'b0);
    send_random(40);
    settle();
    set_config(RS_W'(1), 1'b0);
    send_random(40);
    settle();
    set_config(RS_W'(67108864), 1'b0);
    send_random(35);
    settle();
    set_config(RS_W'($urandom_range(3, 27'h7FFFFFF)) | RS_W'(1), 1'b0);
    send_random(35);
    settle();
    set_config(RS_W'(1) << $urandom_range(26), 1'b0);
    no_idle = 1'b1;
    send_random(40);
    settle();
    no_idle = 1'b0;
    set_config('0, 1'b0);
    send_random(20);
    settle();
    set_config(RS_RESET, 1'b1);
    send_random(20);
    settle();
    set_config('1, 1'b0);
    send_random(20);
  endtask

  // result side holds off while a 32-run flush and more items queue up behind it
  task automatic test_output_stall();
    settle();
    set_config(RS_W'(256), 1'b0);
    for (int b = 0; b < 32; b++)
      send_item(MODE_MARK, 6'd8, OFF_W'(b * 512), 32'd1);
    hold_req = 300;
    send_item(MODE_FLUSH, 6'd8, '0, '0);
    send_item(MODE_FLUSH, 6'd9, '0, '0);
    send_random(12);
  endtask

  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= no_idle || ($urandom_range(99) >= 9);
      end
    end
  end

  always @(posedge clk) begin : check_flush
    flush_req_t got;
    flush_req_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.offset = out_ch.flush_offset;
      got.length = out_ch.flush_length;
      got.whole  = out_ch.whole_block;
      got.empty  = out_ch.nothing_dirty;
      got.last   = out_ch.last_run;
      if (pending_flushes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected flush result: off=%h len=%h whole=%b empty=%b last=%b",
                   got.offset, got.length, got.whole, got.empty, got.last);
      end else begin
        want = pending_flushes.pop_front();
        if (got.offset !== want.offset || got.length !== want.length ||
            got.whole !== want.whole || got.empty !== want.empty ||
            got.last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("flush mismatch: want off=%h len=%h whole=%b empty=%b last=%b, %s",
                     want.offset, want.length, want.whole, want.empty, want.last,
                     $sformatf("got off=%h len=%h whole=%b empty=%b last=%b",
                               got.offset, got.length, got.whole, got.empty, got.last));
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = REG_RANGE_SIZE;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_MARK;
    in_ch.block_index = '0;
    in_ch.byte_offset = '0;
    in_ch.byte_length = '0;
    shadow_range = RS_RESET;
    shadow_coherent = 1'b0;
    for (int i = 0; i < 64; i++)
      shadow_masks[i] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_after_reset();
    test_mark_edges();
    test_coherent_marks();
    test_range_sizes();
    test_random_traffic();
    test_output_stall();
    settle();
    if (mismatch_count == 0 && pending_flushes.size() == 0)
      $display("dirty_range_flush_tracker_test passed");
    else
      $display("dirty_range_flush_tracker_test failed");
    $finish;
  end

endmodule
